FILE: rtl/core/m4xf_pkg.sv
// Shared types, command codes and fixed-point constants for the 4x4 matrix transform unit.
`timescale 1ns / 1ps

package m4xf_pkg;

  // Fractional bits of the Q format and the widths that follow from it.
  localparam int FRAC_BITS = 16;
  localparam int TERM_W    = 64 - FRAC_BITS;
  localparam int SUM_W     = TERM_W + 2;

  localparam logic [31:0] ONE_FIX = 32'(64'd1 << FRAC_BITS);

  localparam logic [31:0] RES_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RES_MIN = 32'h8000_0000;

  // Command codes carried in the cmd field.
  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_IDENT = 3'd1;
  localparam logic [2:0] CMD_TRANS = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_POINT = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [1:0]         column_index;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
  } item_t;

  typedef struct packed {
    logic signed [31:0] res0;
    logic signed [31:0] res1;
    logic signed [31:0] res2;
    logic signed [31:0] res3;
    logic               saturated;
  } result_t;

  // Per-lane control from the issue stage.
  typedef struct packed {
    logic en;     // capture new terms
    logic point;  // point transform: column 3 term is the translation entry
    logic zero;   // row forced to zero (row 3 of a point transform)
  } lane_ctl_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic signed [31:0] value;
    logic               sat;
  } lane_res_t;

  // Reset / identity value of matrix entry i (column major, diagonal at i % 5 == 0).
  function automatic logic [31:0] ident_entry(input logic [3:0] i);
    logic [31:0] v;
    v = ((i == 4'd0) || (i == 4'd5) || (i == 4'd10) || (i == 4'd15)) ? ONE_FIX : 32'd0;
    return v;
  endfunction

endpackage

FILE: rtl/core/m4xf_lane.sv
// One row lane: four products registered, then an exact sum saturated to 32 bits.
`timescale 1ns / 1ps

module m4xf_lane (
  input  logic                  clk,
  input  m4xf_pkg::lane_ctl_t   ctl,
  input  logic [3:0][31:0]      row_m,
  input  logic [3:0][31:0]      elem,
  output m4xf_pkg::lane_res_t   res
);

  localparam logic signed [m4xf_pkg::SUM_W-1:0] SUM_MAX =
    m4xf_pkg::SUM_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [m4xf_pkg::SUM_W-1:0] SUM_MIN =
    m4xf_pkg::SUM_W'(64'shFFFF_FFFF_8000_0000);

  logic signed [63:0]                   prod      [4];
  logic signed [m4xf_pkg::TERM_W-1:0]   term_next [4];
  logic signed [m4xf_pkg::TERM_W-1:0]   term      [4];
  logic                                 zero;
  logic signed [m4xf_pkg::SUM_W-1:0]    sum;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k]      = $signed(row_m[k]) * $signed(elem[k]);
      term_next[k] = m4xf_pkg::TERM_W'(prod[k] >>> m4xf_pkg::FRAC_BITS);
    end
    // For a point, w is one: the translation entry enters unshifted.
    if (ctl.point) begin
      term_next[3] = m4xf_pkg::TERM_W'($signed(row_m[3]));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < 4; k++) begin
        term[k] <= term_next[k];
      end
      zero <= ctl.zero;
    end
  end

  always_comb begin
    sum = m4xf_pkg::SUM_W'(term[0]) + m4xf_pkg::SUM_W'(term[1])
        + m4xf_pkg::SUM_W'(term[2]) + m4xf_pkg::SUM_W'(term[3]);
    if (zero) begin
      res.value = '0;
      res.sat   = 1'b0;
    end else if (sum > SUM_MAX) begin
      res.value = $signed(m4xf_pkg::RES_MAX);
      res.sat   = 1'b1;
    end else if (sum < SUM_MIN) begin
      res.value = $signed(m4xf_pkg::RES_MIN);
      res.sat   = 1'b1;
    end else begin
      res.value = 32'(sum);
      res.sat   = 1'b0;
    end
  end

endmodule

FILE: rtl/core/m4xf_merge.sv
// Merging stage: gathers the four lane results and the saturation flag into the output register.
`timescale 1ns / 1ps

module m4xf_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  issue_valid,
  input  m4xf_pkg::lane_res_t   lane_res [4],
  input  logic                  result_ready,
  output logic                  result_valid,
  output m4xf_pkg::result_t     result,
  output logic                  advance
);

  m4xf_pkg::result_t result_next;

  // The output register can take a new beat when it is empty or being drained.
  assign advance = !result_valid || result_ready;

  always_comb begin
    result_next.res0      = lane_res[0].value;
    result_next.res1      = lane_res[1].value;
    result_next.res2      = lane_res[2].value;
    result_next.res3      = lane_res[3].value;
    result_next.saturated = lane_res[0].sat | lane_res[1].sat
                          | lane_res[2].sat | lane_res[3].sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && issue_valid) begin
      result <= result_next;
    end
  end

endmodule

FILE: rtl/core/matrix4_transform_unit.sv
// Top level of the 4x4 Q16.16 matrix transform unit: matrix registers, four row lanes, merge.
`timescale 1ns / 1ps

// Channel   Signals                          Beat content
// -------   ------------------------------   ---------------------------------------------
// item      item_valid, item_ready, item     command, column index, four column elements
// result    result_valid, result_ready,      four result rows and the saturation flag
//           result
//
// One beat can be taken every cycle while the lane stage is empty or the output register
// takes its beat. A multiply or point beat reaches the result channel through the lane
// term registers, loaded at the accepting edge, and then the output register, which takes
// the sum and saturation unless result_ready stalls it. Load and set beats update the
// matrix at the accepting edge and give no result, so a following beat sees the new matrix.
// Reset loads the identity matrix and empties the pipeline. A stall on result_ready
// holds the output register; the lane stage keeps accepting until it is full too.

module matrix4_transform_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  m4xf_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_ready,
  output m4xf_pkg::result_t   result
);

  // Held matrix, column major: entry c*4 + r is row r of column c.
  logic [31:0] mat [16];

  logic                  accept;
  logic                  issue_en;
  logic                  issue_valid;
  logic                  advance;
  logic                  gives_result;
  logic [3:0][31:0]      elem;
  m4xf_pkg::lane_ctl_t   lane_ctl [4];
  m4xf_pkg::lane_res_t   lane_res [4];

  // The lane stage moves when it is empty or when the output register takes its beat.
  assign issue_en     = !issue_valid || advance;
  assign item_ready   = issue_en;
  assign accept       = item_valid && item_ready;
  assign gives_result = (item.cmd == m4xf_pkg::CMD_MUL) || (item.cmd == m4xf_pkg::CMD_POINT);
  assign elem         = {item.elem3, item.elem2, item.elem1, item.elem0};

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_valid <= 1'b0;
    end else if (issue_en) begin
      issue_valid <= accept && gives_result;
    end
  end

  // Matrix updates from load and set commands. Unused command codes change nothing.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= m4xf_pkg::ident_entry(4'(i));
      end
    end else if (accept) begin
      case (item.cmd)
        m4xf_pkg::CMD_LOAD: begin
          for (int r = 0; r < 4; r++) begin
            mat[{item.column_index, 2'(r)}] <= elem[r];
          end
        end
        m4xf_pkg::CMD_IDENT: begin
          for (int i = 0; i < 16; i++) begin
            mat[i] <= m4xf_pkg::ident_entry(4'(i));
          end
        end
        m4xf_pkg::CMD_TRANS: begin
          for (int i = 0; i < 12; i++) begin
            mat[i] <= m4xf_pkg::ident_entry(4'(i));
          end
          mat[12] <= item.elem0;
          mat[13] <= item.elem1;
          mat[14] <= item.elem2;
          mat[15] <= m4xf_pkg::ONE_FIX;
        end
        default: begin
        end
      endcase
    end
  end

  // One lane per matrix row; each lane sees its own row of the held matrix.
  for (genvar r = 0; r < 4; r++) begin : g_lane
    always_comb begin
      lane_ctl[r].en    = issue_en;
      lane_ctl[r].point = (item.cmd == m4xf_pkg::CMD_POINT);
      lane_ctl[r].zero  = (item.cmd == m4xf_pkg::CMD_POINT) && (r == 3);
    end

    m4xf_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl[r]),
      .row_m ({mat[12 + r], mat[8 + r], mat[4 + r], mat[r]}),
      .elem  (elem),
      .res   (lane_res[r])
    );
  end

  m4xf_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .issue_valid  (issue_valid),
    .lane_res     (lane_res),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result),
    .advance      (advance)
  );

  // A beat waiting in the lane stage is never dropped while the output is stalled.
  a_issue_held: assert property (@(posedge clk) disable iff (rst)
    issue_valid && !advance |=> issue_valid)
    else $error("lane stage beat lost during output stall");

  // A saturated result carries at least one clipped row value.
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      (result.res0 == m4xf_pkg::RES_MAX) || (result.res0 == m4xf_pkg::RES_MIN) ||
      (result.res1 == m4xf_pkg::RES_MAX) || (result.res1 == m4xf_pkg::RES_MIN) ||
      (result.res2 == m4xf_pkg::RES_MAX) || (result.res2 == m4xf_pkg::RES_MIN) ||
      (result.res3 == m4xf_pkg::RES_MAX) || (result.res3 == m4xf_pkg::RES_MIN))
    else $error("saturation flag without a clipped value");

  // Reset leaves the identity matrix and an empty pipeline.
  a_reset_ident: assert property (@(posedge clk)
    rst |=> (mat[0] == m4xf_pkg::ONE_FIX) && (mat[15] == m4xf_pkg::ONE_FIX) &&
            (mat[12] == 32'd0) && !issue_valid && !result_valid)
    else $error("state after reset is not identity and empty");

endmodule
